[src/cmdseg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdseg_pkg
// shared types and constants of the command segmenter
// ----------------------------------------------------------------------------
package cmdseg_pkg;

  localparam int BYTE_W      = 8;
  localparam int ID_W        = 16;
  localparam int LEN_W       = 4;
  localparam int DATA_W      = 64;
  localparam int QUEUE_DEPTH = 2;

  // kind of a classified command byte
  localparam logic [1:0] KIND_ADDR    = 2'd0;
  localparam logic [1:0] KIND_FUNC    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

endpackage
`default_nettype wire

[src/cmdseg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdseg_if
// stream interfaces for command bytes and for frames
// ----------------------------------------------------------------------------
interface cmdseg_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       end_of_command;

  modport source (output valid, cmd_byte, end_of_command, input ready);
  modport sink   (input valid, cmd_byte, end_of_command, output ready);
endinterface

interface cmdseg_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_id;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;
  logic        final_frame;

  modport source (output valid, frame_id, frame_length, frame_data, final_frame, input ready);
  modport sink   (input valid, frame_id, frame_length, frame_data, final_frame, output ready);
endinterface
`default_nettype wire

[src/cmdseg_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdseg_front
// accepts command bytes and tags them as address, function code or payload
// ----------------------------------------------------------------------------
module cmdseg_front
  import cmdseg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  cmdseg_cmd_if.sink    cmd,
  output item_t         q_item,
  output logic          q_valid,
  input  wire logic     q_ready
);

  localparam logic [1:0] HDR_ADDR    = 2'd0;
  localparam logic [1:0] HDR_FUNC    = 2'd1;
  localparam logic [1:0] HDR_PAYLOAD = 2'd2;

  logic [1:0] header_count;
  logic [1:0] header_count_next;
  logic       take;
  logic       drop;

  assign cmd.ready = q_ready;
  assign take      = cmd.valid && q_ready;

  always_comb begin
    header_count_next = header_count;
    q_item.data       = cmd.cmd_byte;
    q_item.last       = cmd.end_of_command;
    drop              = 1'b0;
    case (header_count)
      HDR_ADDR: begin
        q_item.kind = KIND_ADDR;
        drop        = cmd.end_of_command;
        header_count_next = cmd.end_of_command ? HDR_ADDR : HDR_FUNC;
      end
      HDR_FUNC: begin
        q_item.kind = KIND_FUNC;
        drop        = cmd.end_of_command;
        header_count_next = cmd.end_of_command ? HDR_ADDR : HDR_PAYLOAD;
      end
      default: begin
        q_item.kind = KIND_PAYLOAD;
        header_count_next = cmd.end_of_command ? HDR_ADDR : HDR_PAYLOAD;
      end
    endcase
  end

  // header bytes that close a command leave nothing to do downstream
  assign q_valid = take && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= HDR_ADDR;
    end else if (take) begin
      header_count <= header_count_next;
    end
  end

endmodule
`default_nettype wire

[src/cmdseg_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdseg_queue
// two-entry queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module cmdseg_queue
  import cmdseg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  item_t      wr_item,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  output item_t      rd_item,
  output logic       rd_valid,
  input  wire logic  rd_ready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/cmdseg_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdseg_back
// collects payload bytes and emits frames from an output register
// ----------------------------------------------------------------------------
module cmdseg_back
  import cmdseg_pkg::*;
#(
  parameter int FRAME_BYTES = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  item_t         q_item,
  input  wire logic     q_valid,
  output logic          q_ready,
  cmdseg_frame_if.source frame
);

  localparam int PAYLOAD_BYTES = FRAME_BYTES - 1;
  localparam int PEND_W        = PAYLOAD_BYTES * BYTE_W;
  localparam int CNT_W         = (FRAME_BYTES > 2) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [BYTE_W-1:0] address_reg;
  logic [BYTE_W-1:0] function_reg;
  logic [PEND_W-1:0] pending_bytes;
  logic [PEND_W-1:0] pending_bytes_next;
  logic [CNT_W-1:0]  pending_count;
  logic [BYTE_W-1:0] packet_number;
  logic              take;
  logic              is_payload;
  logic              at_full;
  logic              emit;

  assign q_ready    = !frame.valid || frame.ready;
  assign take       = q_valid && q_ready;
  assign is_payload = (q_item.kind == KIND_PAYLOAD);
  assign at_full    = (pending_count == CNT_W'(PAYLOAD_BYTES - 1));
  assign emit       = take && is_payload && (at_full || q_item.last);

  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      pending_bytes_next[i*BYTE_W +: BYTE_W] =
        (CNT_W'(i) == pending_count) ? q_item.data : pending_bytes[i*BYTE_W +: BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame.frame_id     <= {address_reg, packet_number};
      frame.frame_length <= LEN_W'(pending_count) + LEN_W'(2);
      frame.frame_data   <= DATA_W'({pending_bytes_next, function_reg});
      frame.final_frame  <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid   <= 1'b0;
      address_reg   <= '0;
      function_reg  <= '0;
      pending_bytes <= '0;
      pending_count <= '0;
      packet_number <= '0;
    end else begin
      if (emit) begin
        frame.valid <= 1'b1;
      end else if (frame.ready) begin
        frame.valid <= 1'b0;
      end
      if (take) begin
        case (q_item.kind)
          KIND_ADDR: begin
            address_reg <= q_item.data;
          end
          KIND_FUNC: begin
            function_reg  <= q_item.data;
            pending_bytes <= '0;
            pending_count <= '0;
          end
          KIND_PAYLOAD: begin
            if (q_item.last) begin
              address_reg   <= '0;
              function_reg  <= '0;
              pending_bytes <= '0;
              pending_count <= '0;
              packet_number <= '0;
            end else if (at_full) begin
              pending_bytes <= '0;
              pending_count <= '0;
              packet_number <= packet_number + 1'b1;
            end else begin
              pending_bytes <= pending_bytes_next;
              pending_count <= pending_count + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[src/can_command_segmenter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_command_segmenter
// cuts addressed command byte streams into CAN frames with a 16-bit frame_id
//
//   channel   dir   payload                                        accept
//   cmd       in    cmd_byte, end_of_command                       valid & ready
//   frame     out   frame_id, frame_length, frame_data, final_frame valid & ready
//
// one command byte per cycle while cmd.ready is high; the byte that closes a
// frame is held in the two-entry queue, then the frame is loaded into the frame output register
// cmd.ready drops only when the queue is full, which happens only after the
// frame output register has stalled
// synchronous reset clears header phase, pending bytes and packet number
// ----------------------------------------------------------------------------
module can_command_segmenter
  import cmdseg_pkg::*;
#(
  parameter int FRAME_BYTES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  cmdseg_cmd_if.sink     cmd,
  cmdseg_frame_if.source frame
);

  item_t fq_item;
  logic  fq_valid;
  logic  fq_ready;
  item_t qb_item;
  logic  qb_valid;
  logic  qb_ready;

  cmdseg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_item  (fq_item),
    .q_valid (fq_valid),
    .q_ready (fq_ready)
  );

  cmdseg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (fq_item),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .rd_item  (qb_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready)
  );

  cmdseg_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (qb_item),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .frame   (frame)
  );

endmodule
`default_nettype wire

[test/can_command_segmenter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_command_segmenter_tb
// self-checking bench for the CAN command segmenter
//
// a queue of command bytes feeds a clocked driver on the cmd channel; each
// accepted byte runs through a segmenter model of the block's own, and any
// frame it closes goes on a queue of expected frames. a clocked monitor
// compares every frame accepted on the frame channel field by field with
// the oldest expected frame. directed commands come first, then random ones,
// including long commands of several frames. both sides idle at
// random; the receiver also holds off for a long stretch once, and the
// sender at times waits for every expected frame to arrive
// ----------------------------------------------------------------------------
module can_command_segmenter_tb;
  import cmdseg_pkg::*;

  localparam int FRAME_BYTES = 8;
  localparam int PAYLOAD_PER_FRAME = FRAME_BYTES - 1;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_BYTE = 120;
  localparam int IDLE_PCT = 19;
  localparam int QUIET_FROM = 260;
  localparam int QUIET_TO = 340;
  localparam int RANDOM_ITEMS = 400;

  typedef enum logic [1:0] {PH_ADDR, PH_FUNC, PH_PAYLOAD} phase_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic fin;
    bit drain;
  } cmd_item_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [LEN_W-1:0] len;
    logic [DATA_W-1:0] data;
    logic fin;
  } can_frame_t;

  logic clk = 1'b0;
  logic rst;

  cmdseg_cmd_if cmd_ch ();
  cmdseg_frame_if frame_ch ();

  can_command_segmenter #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .frame(frame_ch)
  );

  cmd_item_t cmd_items[$];
  can_frame_t frames_expected[$];
  int errors = 0;
  int cycle = 0;
  int bytes_in = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 0;

  // segmenter state
  phase_t phase;
  logic [BYTE_W-1:0] cur_addr;
  logic [BYTE_W-1:0] cur_func;
  logic [63:0] pend;
  int pend_count;
  logic [7:0] pkt_num;

  always #5 clk = ~clk;

  function automatic void clear_command();
    phase = PH_ADDR;
    cur_addr = '0;
    cur_func = '0;
    pend = '0;
    pend_count = 0;
    pkt_num = '0;
  endfunction

  function automatic bit segment_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                      output can_frame_t f);
    int cnt;
    f = '0;
    if (phase == PH_ADDR) begin
      if (fin) clear_command();
      else begin
        cur_addr = b;
        phase = PH_FUNC;
      end
      return 0;
    end
    if (phase == PH_FUNC) begin
      if (fin) clear_command();
      else begin
        cur_func = b;
        phase = PH_PAYLOAD;
        pend = '0;
        pend_count = 0;
      end
      return 0;
    end
    cnt = pend_count;
    if (cnt >= PAYLOAD_PER_FRAME) begin
      cnt = 0;
      pend = '0;
    end
    pend[8*cnt +: 8] = b;
    cnt++;
    if (cnt < PAYLOAD_PER_FRAME && !fin) begin
      pend_count = cnt;
      return 0;
    end
    f.id = {cur_addr, pkt_num};
    f.len = LEN_W'(cnt + 1);
    f.data = 64'(cur_func) | (pend << 8);
    f.fin = fin;
    if (fin) clear_command();
    else begin
      pkt_num = pkt_num + 8'd1;
      pend = '0;
      pend_count = 0;
    end
    return 1;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin, input bit drain = 0);
    cmd_item_t it;
    it.b = b;
    it.fin = fin;
    it.drain = drain;
    cmd_items = {cmd_items, it};
  endtask

  // well-formed command with random content
  task automatic push_command(input int npay, input bit drain = 0);
    push_byte(BYTE_W'($urandom), 1'b0, drain);
    push_byte(BYTE_W'($urandom), 1'b0);
    for (int i = 0; i < npay; i++) push_byte(BYTE_W'($urandom), i == npay - 1);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
  endtask

  function automatic bit idle_now();
    if (bytes_in >= QUIET_FROM && bytes_in < QUIET_TO) return 0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // driver
  always @(posedge clk) begin
    cmd_item_t nxt;
    can_frame_t f;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.cmd_byte <= '0;
      cmd_ch.end_of_command <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        bytes_in++;
        if (segment_byte(cmd_ch.cmd_byte, cmd_ch.end_of_command, f))
          frames_expected = {frames_expected, f};
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_items.size() > 0 && !idle_now() &&
            !(cmd_items[0].drain && frames_expected.size() > 0)) begin
          nxt = cmd_items.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.cmd_byte <= nxt.b;
          cmd_ch.end_of_command <= nxt.fin;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
        hold_done <= 1;
        hold_left <= HOLD_CYCLES;
        frame_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= !idle_now();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    can_frame_t e;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (frames_expected.size() == 0) begin
        report_mismatch("unexpected frame_id", 64'(frame_ch.frame_id), '0);
      end else begin
        e = frames_expected.pop_front();
        if (frame_ch.frame_id !== e.id)
          report_mismatch("frame_id", 64'(frame_ch.frame_id), 64'(e.id));
        if (frame_ch.frame_length !== e.len)
          report_mismatch("frame_length", 64'(frame_ch.frame_length), 64'(e.len));
        if (frame_ch.frame_data !== e.data)
          report_mismatch("frame_data", frame_ch.frame_data, e.data);
        if (frame_ch.final_frame !== e.fin)
          report_mismatch("final_frame", 64'(frame_ch.final_frame), 64'(e.fin));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    rst = 1'b1;
    clear_command();

    // command ending on its address
    push_byte(8'hFF, 1'b1);
    // command ending on its function code
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // single payload byte
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // last frame exactly full
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    for (int i = 0; i < PAYLOAD_PER_FRAME; i++)
      push_byte((i % 2) ? 8'hFF : 8'h00, i == PAYLOAD_PER_FRAME - 1);
    // one full frame then a short final frame
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    for (int i = 0; i < PAYLOAD_PER_FRAME + 1; i++)
      push_byte(8'h11 * i[7:0], i == PAYLOAD_PER_FRAME);

    while (cmd_items.size() < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_byte(BYTE_W'($urandom), 1'($urandom));
      end else if (r < 14) begin
        push_byte(BYTE_W'($urandom), 1'b0);
        push_byte(BYTE_W'($urandom), 1'b1);
      end else if (r < 80) begin
        push_command($urandom_range(1, 16), cmd_items.size() > 200 && cmd_items.size() < 215);
      end else if (r < 90) begin
        push_command(PAYLOAD_PER_FRAME * $urandom_range(1, 3));
      end else begin
        push_command($urandom_range(17, 40));
      end
    end
    // sender waits for every outstanding frame
    push_command($urandom_range(1, 10), 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (cmd_items.size() > 0 || cmd_ch.valid || frames_expected.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && frames_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
src/cmdseg_pkg.sv
src/cmdseg_if.sv
src/cmdseg_front.sv
src/cmdseg_queue.sv
src/cmdseg_back.sv
src/can_command_segmenter.sv
test/can_command_segmenter_tb.sv
